// ===== sv/atan2p_pkg.sv =====
// ----------------------------------------------------------------------------
// atan2p_pkg
// Widths, fixed-point constants and helpers for the pipelined atan2 block.
// ----------------------------------------------------------------------------
package atan2p_pkg;

    localparam int IN_WIDTH        = 16;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int ANGLE_WIDTH     = ANGLE_FRAC_BITS + 3;

    localparam int RATIO_FRAC = 15;
    localparam int POLY_FRAC  = 30;
    localparam int QW         = RATIO_FRAC + 1;
    localparam int DIV_STAGES = QW / 2;
    localparam int DW         = IN_WIDTH + RATIO_FRAC;
    localparam int SW         = 2 * RATIO_FRAC + 1;
    localparam int NSTEPS     = 4;
    localparam int SHIFT_N    = POLY_FRAC - ANGLE_FRAC_BITS;

    localparam int S_TDATA_W = ((2 * IN_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W = ((ANGLE_WIDTH + 7) / 8) * 8;

    localparam logic signed [31:0] K_C9 = 32'sd22371518;
    localparam logic signed [31:0] HORNER_C [NSTEPS] = '{
        -32'sd91410863, 32'sd193424926, -32'sd354656388, 32'sd1073597943
    };
    localparam logic signed [33:0] K_HALF_PI = 34'sd1686629713;
    localparam logic signed [33:0] K_PI      = 34'sd3373259426;
    localparam logic signed [33:0] ANGLE_LIM = (34'sd1 <<< (ANGLE_WIDTH - 1)) - 34'sd1;

    typedef struct packed {
        logic zero;
        logic pq;
        logic neg_p;
        logic y_neg;
        logic x_neg;
    } info_t;

    // one restoring step: returns {new remainder, quotient bit}
    function automatic logic [IN_WIDTH:0] div_step(input logic [IN_WIDTH-1:0] rem,
                                                   input logic nb,
                                                   input logic [IN_WIDTH-1:0] mx);
        logic [IN_WIDTH:0] t;
        logic [IN_WIDTH:0] d;
        t = {rem, nb};
        d = t - {1'b0, mx};
        if (t >= {1'b0, mx}) begin
            return {d[IN_WIDTH-1:0], 1'b1};
        end else begin
            return {t[IN_WIDTH-1:0], 1'b0};
        end
    endfunction

endpackage

// ===== sv/atan2_polynomial_approx.sv =====
// ----------------------------------------------------------------------------
// atan2_polynomial_approx
// Structure: 22 register stages, which all hold while the output side stalls.
// Throughput: one request per clock while the output side does not stall; the
//   2-bit-per-stage ratio divider and the Horner multiplier stages are fully pipelined.
// Reset: synchronous, active low; clears all stage valid bits only.
// Ratio divider, odd degree-9 Horner polynomial, quadrant fix, rounding and saturation.
// ----------------------------------------------------------------------------
module atan2_polynomial_approx import atan2p_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // coord_y, coord_x
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // angle
    output logic [0:0]           m_tuser    // undefined
);

    logic ce;
    assign ce       = ~m_tvalid | m_tready;
    assign s_tready = ce;

    // ---------------- input stage: magnitudes and ordering
    logic signed [IN_WIDTH-1:0] y_in, x_in;
    logic [IN_WIDTH-1:0] ay, ax;
    info_t in_info_next;

    assign y_in = s_tdata[IN_WIDTH-1:0];
    assign x_in = s_tdata[2*IN_WIDTH-1:IN_WIDTH];
    assign ay   = y_in[IN_WIDTH-1] ? (~y_in + 1'b1) : y_in;
    assign ax   = x_in[IN_WIDTH-1] ? (~x_in + 1'b1) : x_in;

    always_comb begin
        in_info_next.zero  = (ay == '0) && (ax == '0);
        in_info_next.pq    = ay < ax;
        in_info_next.y_neg = y_in[IN_WIDTH-1];
        in_info_next.x_neg = x_in[IN_WIDTH-1];
        in_info_next.neg_p = (y_in[IN_WIDTH-1] ^ x_in[IN_WIDTH-1]) ^ ~(ay < ax);
    end

    logic                in_vld_reg;
    logic [IN_WIDTH-1:0] mn_reg, mx_reg;
    info_t               in_info_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (ce) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            mn_reg      <= in_info_next.pq ? ay : ax;
            mx_reg      <= in_info_next.pq ? ax : ay;
            in_info_reg <= in_info_next;
        end
    end

    // ---------------- ratio divider, two quotient bits per stage
    logic [DW-1:0] num;
    assign num = {mn_reg, {RATIO_FRAC{1'b0}}} + DW'(mx_reg >> 1);

    logic                dv_vld_reg  [DIV_STAGES];
    logic [IN_WIDTH-1:0] dv_rem_reg  [DIV_STAGES];
    logic [QW-1:0]       dv_lq_reg   [DIV_STAGES];  // dividend bits out, quotient bits in
    logic [IN_WIDTH-1:0] dv_mx_reg   [DIV_STAGES];
    info_t               dv_info_reg [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        logic [IN_WIDTH-1:0] rem_in, mx_in;
        logic [QW-1:0]       lq_in;
        info_t               info_in;
        logic                vld_in;
        logic [IN_WIDTH:0]   st1, st2;

        if (k == 0) begin : g_first
            assign rem_in  = IN_WIDTH'(num[DW-1:QW]);
            assign lq_in   = num[QW-1:0];
            assign mx_in   = mx_reg;
            assign info_in = in_info_reg;
            assign vld_in  = in_vld_reg;
        end else begin : g_next
            assign rem_in  = dv_rem_reg[k-1];
            assign lq_in   = dv_lq_reg[k-1];
            assign mx_in   = dv_mx_reg[k-1];
            assign info_in = dv_info_reg[k-1];
            assign vld_in  = dv_vld_reg[k-1];
        end

        assign st1 = div_step(rem_in, lq_in[QW-1], mx_in);
        assign st2 = div_step(st1[IN_WIDTH:1], lq_in[QW-2], mx_in);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[k] <= 1'b0;
            end else if (ce) begin
                dv_vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                dv_rem_reg[k]  <= st2[IN_WIDTH:1];
                dv_lq_reg[k]   <= {lq_in[QW-3:0], st1[0], st2[0]};
                dv_mx_reg[k]   <= mx_in;
                dv_info_reg[k] <= info_in;
            end
        end
    end

    // ---------------- square of the ratio
    logic [QW-1:0] ratio;
    assign ratio = dv_lq_reg[DIV_STAGES-1];

    logic          sq_vld_reg;
    logic [QW-1:0] sq_a_reg;
    logic [SW-1:0] sq_s_reg;
    info_t         sq_info_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg <= 1'b0;
        end else if (ce) begin
            sq_vld_reg <= dv_vld_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sq_a_reg    <= ratio;
            sq_s_reg    <= SW'(ratio * ratio);
            sq_info_reg <= dv_info_reg[DIV_STAGES-1];
        end
    end

    // ---------------- Horner steps: multiply stage, then round and add stage
    logic               hm_vld_reg  [NSTEPS];
    logic signed [63:0] hm_prod_reg [NSTEPS];
    logic [QW-1:0]      hm_a_reg    [NSTEPS];
    logic [SW-1:0]      hm_s_reg    [NSTEPS];
    info_t              hm_info_reg [NSTEPS];

    logic               ha_vld_reg  [NSTEPS];
    logic signed [31:0] ha_r_reg    [NSTEPS];
    logic [QW-1:0]      ha_a_reg    [NSTEPS];
    logic [SW-1:0]      ha_s_reg    [NSTEPS];
    info_t              ha_info_reg [NSTEPS];

    for (genvar k = 0; k < NSTEPS; k++) begin : g_horner
        logic signed [31:0] r_in;
        logic [QW-1:0]      a_in;
        logic [SW-1:0]      s_in;
        info_t              info_in;
        logic               vld_in;
        logic signed [63:0] prod;
        logic signed [63:0] rnd;

        if (k == 0) begin : g_first
            assign r_in    = K_C9;
            assign a_in    = sq_a_reg;
            assign s_in    = sq_s_reg;
            assign info_in = sq_info_reg;
            assign vld_in  = sq_vld_reg;
        end else begin : g_next
            assign r_in    = ha_r_reg[k-1];
            assign a_in    = ha_a_reg[k-1];
            assign s_in    = ha_s_reg[k-1];
            assign info_in = ha_info_reg[k-1];
            assign vld_in  = ha_vld_reg[k-1];
        end

        assign prod = r_in * $signed({1'b0, s_in});
        assign rnd  = hm_prod_reg[k] + (64'sd1 <<< (POLY_FRAC - 1));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                hm_vld_reg[k] <= 1'b0;
                ha_vld_reg[k] <= 1'b0;
            end else if (ce) begin
                hm_vld_reg[k] <= vld_in;
                ha_vld_reg[k] <= hm_vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                hm_prod_reg[k] <= prod;
                hm_a_reg[k]    <= a_in;
                hm_s_reg[k]    <= s_in;
                hm_info_reg[k] <= info_in;
                ha_r_reg[k]    <= $signed(rnd[POLY_FRAC+31:POLY_FRAC]) + HORNER_C[k];
                ha_a_reg[k]    <= hm_a_reg[k];
                ha_s_reg[k]    <= hm_s_reg[k];
                ha_info_reg[k] <= hm_info_reg[k];
            end
        end
    end

    // ---------------- final odd factor, sign, quadrant shift, output rounding and saturation
    logic               pm_vld_reg;
    logic signed [63:0] pm_prod_reg;
    info_t              pm_info_reg;

    logic               pr_vld_reg;
    logic signed [32:0] pr_atan_reg;
    info_t              pr_info_reg;

    logic               tot_vld_reg;
    logic signed [33:0] tot_sum_reg;
    logic               tot_zero_reg;

    logic signed [63:0] p_rnd;
    logic signed [32:0] p_ext;
    logic signed [33:0] t3, shift;
    logic signed [33:0] out_rnd, out_sh, out_sat;

    assign p_rnd = pm_prod_reg + (64'sd1 <<< (RATIO_FRAC - 1));
    assign p_ext = 33'(signed'(p_rnd[RATIO_FRAC+31:RATIO_FRAC]));

    assign t3    = pr_info_reg.pq ? (pr_info_reg.x_neg ? K_PI : 34'sd0) : K_HALF_PI;
    assign shift = pr_info_reg.y_neg ? -t3 : t3;

    assign out_rnd = tot_sum_reg + (34'sd1 <<< (SHIFT_N - 1));
    assign out_sh  = out_rnd >>> SHIFT_N;

    always_comb begin
        if (out_sh > ANGLE_LIM) begin
            out_sat = ANGLE_LIM;
        end else if (out_sh < -ANGLE_LIM) begin
            out_sat = -ANGLE_LIM;
        end else begin
            out_sat = out_sh;
        end
    end

    logic                          m_tvalid_reg;
    logic signed [ANGLE_WIDTH-1:0] angle_reg;
    logic                          undef_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pm_vld_reg   <= 1'b0;
            pr_vld_reg   <= 1'b0;
            tot_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            pm_vld_reg   <= ha_vld_reg[NSTEPS-1];
            pr_vld_reg   <= pm_vld_reg;
            tot_vld_reg  <= pr_vld_reg;
            m_tvalid_reg <= tot_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            pm_prod_reg  <= ha_r_reg[NSTEPS-1] * $signed({1'b0, ha_a_reg[NSTEPS-1]});
            pm_info_reg  <= ha_info_reg[NSTEPS-1];
            pr_atan_reg  <= pm_info_reg.neg_p ? -p_ext : p_ext;
            pr_info_reg  <= pm_info_reg;
            tot_sum_reg  <= 34'(pr_atan_reg) + shift;
            tot_zero_reg <= pr_info_reg.zero;
            angle_reg    <= tot_zero_reg ? '0 : out_sat[ANGLE_WIDTH-1:0];
            undef_reg    <= tot_zero_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(unsigned'(angle_reg));
    assign m_tuser  = undef_reg;

    // ---------------- checks
    a_ratio_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_vld_reg && !sq_info_reg.zero |-> sq_a_reg <= QW'(1 << RATIO_FRAC))
        else $error("ratio above one");

    a_undef_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> angle_reg == '0)
        else $error("undefined result with nonzero angle");

    a_sat_sym: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> angle_reg != {1'b1, {(ANGLE_WIDTH-1){1'b0}}})
        else $error("angle outside symmetric range");

    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        ce && tot_vld_reg |=> m_tvalid)
        else $error("request lost at output stage");

endmodule
